// ----- rtl/core/cds_pkg.sv -----
package cds_pkg;

    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YEAR_W  = 14;
    localparam int RES_W   = 9;

    localparam logic [YEAR_W-1:0]  YEAR_MAX = 14'd16383;

    localparam logic [MONTH_W-1:0] DEF_MONTH = 4'd1;
    localparam logic [DAY_W-1:0]   DEF_DAY   = 5'd1;
    localparam logic [YEAR_W-1:0]  DEF_YEAR  = 14'd1900;
    // default year modulo 400
    localparam logic [RES_W-1:0]   DEF_RES   = 9'd300;
    localparam logic [RES_W-1:0]   RES_LAST  = 9'd399;

    // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SHIFT for every 14-bit y
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_INC  = 2'd1,
        OP_DEC  = 2'd2
    } opcode_t;

    // leap rule from the year modulo 400
    function automatic logic leap_from_res(input logic [RES_W-1:0] res);
        leap_from_res = (res[1:0] == 2'd0) &&
                        (res != 9'd100) && (res != 9'd200) && (res != 9'd300);
    endfunction

    // month length, zero for a month out of range
    function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
        case (month)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: days_in = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    days_in = 5'd30;
            4'd2:    days_in = leap ? 5'd29 : 5'd28;
            default: days_in = 5'd0;
        endcase
    endfunction

endpackage

// ----- rtl/core/calendar_date_step.sv -----
// each request passes through the input register, then its result through the result register
// throughput: one item per cycle while m_ready does not stall the output; the held date is updated in the result stage
// the year is tracked modulo 400 alongside the date so the leap rule needs no divider
// reset (synchronous, active low aresetn): date 1/1/1900, both stages empty
module calendar_date_step
    import cds_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_opcode,
    input  logic [MONTH_W-1:0]  s_load_month,
    input  logic [DAY_W-1:0]    s_load_day,
    input  logic [YEAR_W-1:0]   s_load_year,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [MONTH_W-1:0]  m_old_month,
    output logic [DAY_W-1:0]    m_old_day,
    output logic [YEAR_W-1:0]   m_old_year,
    output logic [MONTH_W-1:0]  m_new_month,
    output logic [DAY_W-1:0]    m_new_day,
    output logic [YEAR_W-1:0]   m_new_year,
    output logic                m_load_valid,
    output logic                m_is_default
);

    // input stage
    logic                in_valid_reg;
    opcode_t             op_reg;
    logic [MONTH_W-1:0]  lm_reg;
    logic [DAY_W-1:0]    ld_reg;
    logic [YEAR_W-1:0]   ly_reg;
    logic                load_ok_reg;
    logic [RES_W-1:0]    load_res_reg;

    // held date
    logic [MONTH_W-1:0]  cur_month_reg;
    logic [DAY_W-1:0]    cur_day_reg;
    logic [YEAR_W-1:0]   cur_year_reg;
    logic [RES_W-1:0]    cur_res_reg;

    // result stage
    logic                m_valid_reg;
    logic [MONTH_W-1:0]  old_month_reg;
    logic [DAY_W-1:0]    old_day_reg;
    logic [YEAR_W-1:0]   old_year_reg;
    logic                load_valid_reg;
    logic                is_default_reg;

    logic                advance;
    logic                fire;

    // load-date checks
    logic [26:0]         div_prod;
    logic [7:0]          q100;
    logic [13:0]         q100_x100;
    logic [6:0]          r100;
    logic [RES_W-1:0]    in_res;
    logic [DAY_W-1:0]    in_len;
    logic                in_ok;

    // date update
    logic [DAY_W-1:0]    cur_len;
    logic [DAY_W-1:0]    prev_len;
    logic                cur_leap;
    logic [MONTH_W-1:0]  month_next;
    logic [DAY_W-1:0]    day_next;
    logic [YEAR_W-1:0]   year_next;
    logic [RES_W-1:0]    res_next;
    logic                load_valid_next;

    assign advance = !m_valid_reg || m_ready;
    assign fire    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        div_prod  = 27'(s_load_year) * 27'(DIV100_MUL);
        q100      = div_prod[DIV100_SHIFT +: 8];
        q100_x100 = 14'(q100) * 14'd100;
        r100      = 7'(s_load_year - q100_x100);
        in_res    = 9'(q100[1:0]) * 9'd100 + 9'(r100);
        in_len    = days_in(s_load_month, leap_from_res(in_res));
        in_ok     = (s_load_year != '0) && (s_load_year <= YEAR_MAX) &&
                    (s_load_day != '0) && (s_load_day <= in_len);
    end

    always_comb begin
        cur_leap = leap_from_res(cur_res_reg);
        cur_len  = days_in(cur_month_reg, cur_leap);
        prev_len = days_in(cur_month_reg - 4'd1, cur_leap);

        month_next      = cur_month_reg;
        day_next        = cur_day_reg;
        year_next       = cur_year_reg;
        res_next        = cur_res_reg;
        load_valid_next = 1'b0;

        case (op_reg)
            OP_LOAD: begin
                if (load_ok_reg) begin
                    month_next      = lm_reg;
                    day_next        = ld_reg;
                    year_next       = ly_reg;
                    res_next        = load_res_reg;
                    load_valid_next = 1'b1;
                end else begin
                    month_next = DEF_MONTH;
                    day_next   = DEF_DAY;
                    year_next  = DEF_YEAR;
                    res_next   = DEF_RES;
                end
            end
            OP_INC: begin
                if (cur_day_reg < cur_len) begin
                    day_next = cur_day_reg + 5'd1;
                end else if (cur_month_reg < 4'd12) begin
                    month_next = cur_month_reg + 4'd1;
                    day_next   = 5'd1;
                end else if (cur_year_reg < YEAR_MAX) begin
                    year_next  = cur_year_reg + 14'd1;
                    month_next = 4'd1;
                    day_next   = 5'd1;
                    res_next   = (cur_res_reg == RES_LAST) ? '0 : cur_res_reg + 9'd1;
                end
            end
            OP_DEC: begin
                if (cur_day_reg > 5'd1) begin
                    day_next = cur_day_reg - 5'd1;
                end else if (cur_month_reg > 4'd1) begin
                    month_next = cur_month_reg - 4'd1;
                    day_next   = prev_len;
                end else if (cur_year_reg > 14'd1) begin
                    year_next  = cur_year_reg - 14'd1;
                    month_next = 4'd12;
                    day_next   = 5'd31;
                    res_next   = (cur_res_reg == '0) ? RES_LAST : cur_res_reg - 9'd1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
            cur_month_reg <= DEF_MONTH;
            cur_day_reg   <= DEF_DAY;
            cur_year_reg  <= DEF_YEAR;
            cur_res_reg   <= DEF_RES;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                m_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                cur_month_reg <= month_next;
                cur_day_reg   <= day_next;
                cur_year_reg  <= year_next;
                cur_res_reg   <= res_next;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg       <= opcode_t'(s_opcode);
            lm_reg       <= s_load_month;
            ld_reg       <= s_load_day;
            ly_reg       <= s_load_year;
            load_ok_reg  <= in_ok;
            load_res_reg <= in_res;
        end
        if (fire) begin
            old_month_reg  <= cur_month_reg;
            old_day_reg    <= cur_day_reg;
            old_year_reg   <= cur_year_reg;
            load_valid_reg <= load_valid_next;
            is_default_reg <= (month_next == DEF_MONTH) && (day_next == DEF_DAY) &&
                              (year_next == DEF_YEAR);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_old_month  = old_month_reg;
    assign m_old_day    = old_day_reg;
    assign m_old_year   = old_year_reg;
    assign m_new_month  = cur_month_reg;
    assign m_new_day    = cur_day_reg;
    assign m_new_year   = cur_year_reg;
    assign m_load_valid = load_valid_reg;
    assign m_is_default = is_default_reg;

`ifndef SYNTHESIS
    a_month_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_month_reg >= 4'd1) && (cur_month_reg <= 4'd12))
        else $error("held month out of range");

    a_day_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_day_reg >= 5'd1) && (cur_day_reg <= cur_len))
        else $error("held day beyond month length");

    a_year_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cur_year_reg >= 14'd1) && (cur_year_reg <= YEAR_MAX) && (cur_res_reg <= RES_LAST))
        else $error("held year or year residue out of range");

    a_default_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (is_default_reg == ((cur_month_reg == DEF_MONTH) &&
                         (cur_day_reg == DEF_DAY) && (cur_year_reg == DEF_YEAR))))
        else $error("default flag disagrees with held date");
`endif

endmodule
